/* design/rur_pkg.sv */
// Shared types, constants and the divider step for the RGBA un-premultiply block.
// No dependencies; every other design file imports this package.
package rur_pkg;

    localparam int unsigned NumChan      = 3;
    localparam int unsigned ChanBits     = 8;
    localparam int unsigned RemBits      = 2 * ChanBits;
    localparam int unsigned DivStages    = 4;
    localparam int unsigned BitsPerStage = ChanBits / DivStages;

    localparam logic [ChanBits-1:0] ChanMax = 8'hff;
    localparam logic [ChanBits-1:0] AlphaZero = 8'h00;

    typedef logic [ChanBits-1:0] t_chan;
    typedef logic [RemBits-1:0]  t_rem;

    // Pixel in flight: alpha, raw colors, per-channel partial remainder and quotient.
    typedef struct packed {
        t_chan                    alpha;
        logic                     argb;
        logic [NumChan-1:0]       sat;
        t_chan [NumChan-1:0]      raw;
        t_rem  [NumChan-1:0]      rem;
        t_chan [NumChan-1:0]      quo;
    } t_div_item;

    // Resolve BitsPerStage quotient bits, starting at bit position hi.
    function automatic t_div_item div_step(t_div_item it, int unsigned hi);
        t_div_item        res;
        logic [RemBits:0] trial;
        t_rem             dsr;
        int unsigned      pos;
        res = it;
        for (int unsigned j = 0; j < BitsPerStage; j++) begin
            pos = hi - j;
            for (int unsigned ch = 0; ch < NumChan; ch++) begin
                dsr   = t_rem'({{(RemBits-ChanBits){1'b0}}, res.alpha} << pos);
                trial = {1'b0, res.rem[ch]} - {1'b0, dsr};
                if (!trial[RemBits]) begin
                    res.rem[ch]                      = trial[RemBits-1:0];
                    res.quo[ch][3'(pos)]             = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

/* design/rgba_unpremultiply_reorder.sv */
// Top level: un-premultiply one RGBA8 pixel per request and pack it as RGBA or ARGB.
// Throughput one request per cycle while the sink does not stall; six stages: capture,
// four divider stages (two quotient bits each), pack.
// Reset (i_rst_n low, synchronous) empties every stage and clears argb_order to 0.
// o_stall rises only while the pipeline is full and the sink holds i_stall.
// Depends on rur_pkg, rur_divider, rur_pack.
module rgba_unpremultiply_reorder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_premul_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_pixel
);
    import rur_pkg::*;

    logic      r_argb_order;
    logic      r_s0_vld;
    t_div_item r_s0_item;
    t_div_item n_s0_item;
    logic      w_s0_en;
    logic      w_div_stall;
    logic      w_div_vld;
    t_div_item w_div_item;
    logic      w_pack_stall;

    // Configuration register; write it only while the pipeline is idle (the block does not enforce this).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_argb_order <= 1'b0;
        end else if (i_cfg_we) begin
            r_argb_order <= i_cfg_wdata;
        end
    end

    // Capture stage: split the pixel, flag channels that saturate (color at or
    // above alpha gives a quotient of 255 or more) and form the dividend
    // c*255 + a/2, which then stays below 255*a for the rest.
    always_comb begin
        n_s0_item.alpha = i_premul_pixel[31:24];
        n_s0_item.argb  = r_argb_order;
        for (int unsigned ch = 0; ch < NumChan; ch++) begin
            n_s0_item.raw[ch] = i_premul_pixel[ch*ChanBits +: ChanBits];
            n_s0_item.sat[ch] = n_s0_item.raw[ch] >= n_s0_item.alpha;
            n_s0_item.rem[ch] = {n_s0_item.raw[ch], {ChanBits{1'b0}}}
                              - {{ChanBits{1'b0}}, n_s0_item.raw[ch]}
                              + {{(ChanBits+1){1'b0}}, n_s0_item.alpha[ChanBits-1:1]};
            n_s0_item.quo[ch] = '0;
        end
    end

    // Advance the capture stage when empty or when the divider takes its content.
    assign w_s0_en = !r_s0_vld || !w_div_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_s0_en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_en && i_valid) begin
            r_s0_item <= n_s0_item;
        end
    end

    assign o_stall = !w_s0_en;

    rur_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_vld),
        .o_stall (w_div_stall),
        .i_item  (r_s0_item),
        .o_valid (w_div_vld),
        .i_stall (w_pack_stall),
        .o_item  (w_div_item)
    );

    rur_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_vld),
        .o_stall (w_pack_stall),
        .i_item  (w_div_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_out_pixel)
    );

    // Zero alpha must clear the whole pixel.
    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_pixel[31:24] == AlphaZero) |-> (o_out_pixel == '0))
        else $error("zero-alpha pixel with nonzero color");

    // Back-pressure reaches the source only through a stalled sink.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("upstream stalled while sink is not stalling");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("pipeline not empty after reset");

endmodule

/* design/rur_divider.sv */
// Pipelined restoring divider, three channel lanes, BitsPerStage quotient bits a stage.
// Depends on rur_pkg.
module rur_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rur_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output rur_pkg::t_div_item o_item
);
    import rur_pkg::*;

    logic      r_vld  [DivStages];
    t_div_item r_item [DivStages];
    logic      w_hold [DivStages];

    for (genvar k = 0; k < DivStages; k++) begin : g_stage
        localparam int unsigned Hi = ChanBits - 1 - k * BitsPerStage;
        t_div_item w_src;
        logic      w_src_vld;

        if (k == DivStages - 1) begin : g_last
            assign w_hold[k] = r_vld[k] & i_stall;
        end else begin : g_mid
            assign w_hold[k] = r_vld[k] & w_hold[k+1];
        end

        if (k == 0) begin : g_first
            assign w_src     = i_item;
            assign w_src_vld = i_valid;
        end else begin : g_next
            assign w_src     = r_item[k-1];
            assign w_src_vld = r_vld[k-1];
        end

        // Advance when this stage is empty or its content moves on.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (!w_hold[k]) begin
                r_vld[k] <= w_src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_hold[k] && w_src_vld) begin
                r_item[k] <= div_step(w_src, Hi);
            end
        end
    end

    assign o_stall = w_hold[0];
    assign o_valid = r_vld[DivStages-1];
    assign o_item  = r_item[DivStages-1];

endmodule

/* design/rur_pack.sv */
// Output stage: selects zero, pass-through, saturated or divided channels and packs order.
// Depends on rur_pkg.
module rur_pack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rur_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_pixel
);
    import rur_pkg::*;

    logic        r_vld;
    logic [31:0] r_pixel;
    logic [31:0] n_pixel;
    logic        w_en;
    t_chan       w_ch [NumChan];

    always_comb begin
        for (int unsigned ch = 0; ch < NumChan; ch++) begin
            if (i_item.alpha == ChanMax) begin
                w_ch[ch] = i_item.raw[ch];
            end else if (i_item.sat[ch]) begin
                w_ch[ch] = ChanMax;
            end else begin
                w_ch[ch] = i_item.quo[ch];
            end
        end
        if (i_item.alpha == AlphaZero) begin
            n_pixel = '0;
        end else if (i_item.argb) begin
            n_pixel = {i_item.alpha, w_ch[0], w_ch[1], w_ch[2]};
        end else begin
            n_pixel = {i_item.alpha, w_ch[2], w_ch[1], w_ch[0]};
        end
    end

    assign w_en = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_stall = !w_en;
    assign o_valid = r_vld;
    assign o_pixel = r_pixel;

endmodule

/* tb/sv/tb_rgba_unpremultiply_reorder.sv */
// Self-checking bench for rgba_unpremultiply_reorder: a queue-fed request driver,
// a randomly stalling result sink and an in-line predictor of straight-alpha pixels.
// Depends on the block's top level only; its ports carry plain vectors.
module tb_rgba_unpremultiply_reorder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned SettleCycles = 10;
    localparam int unsigned MaxReports   = 10;
    localparam int unsigned RandPhases   = 5;
    localparam int unsigned RandPerPhase = 110;
    localparam int unsigned DrainAt      = 55;     // request that waits for an empty pipe
    localparam int unsigned LongHold     = 80;
    localparam logic [7:0]  AlphaFull    = 8'hff;
    localparam logic [7:0]  AlphaNone    = 8'h00;

    typedef struct {
        logic [31:0] pixel;
        bit          drain_first;  // hold the request until every result is back
    } t_pixel_req;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_wdata    = 1'b0;
    logic        i_valid        = 1'b0;
    logic [31:0] i_premul_pixel = 32'h0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_out_pixel;

    t_pixel_req  pending_reqs[$];
    logic [31:0] expected_pixels[$];
    bit          argb_mode = 1'b0;     // mirror of the order register
    bit          req_taken = 1'b0;     // set at each rising edge, read at the falling edge
    bit          rsp_taken = 1'b0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    rgba_unpremultiply_reorder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_premul_pixel (i_premul_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_pixel    (o_out_pixel)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Rescale one color byte by a partial alpha, rounding to nearest and
    // clamping malformed input (color above alpha) to full scale.
    function automatic logic [7:0] rescale_chan(logic [7:0] c, logic [7:0] a);
        int unsigned v;
        v = (int'(c) * 255 + int'(a) / 2) / int'(a);
        return (v > 255) ? 8'hff : v[7:0];
    endfunction

    // Expected straight-alpha pixel for one premultiplied request.
    function automatic logic [31:0] unpremul_pixel(logic [31:0] px, bit argb);
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        a = px[31:24];
        if (a == AlphaNone) begin
            return 32'h0;
        end
        if (a == AlphaFull) begin
            // no rescale at full coverage, only the R/B swap for ARGB
            return argb ? {a, px[7:0], px[15:8], px[23:16]} : px;
        end
        r = rescale_chan(px[7:0], a);
        g = rescale_chan(px[15:8], a);
        b = rescale_chan(px[23:16], a);
        return argb ? {a, r, g, b} : {a, b, g, r};
    endfunction

    // Monitor: note both handshakes, predict on accepted requests, check results.
    always @(posedge i_clk) begin
        logic [31:0] want;
        req_taken = i_rst_n && i_valid && !o_stall;
        rsp_taken = i_rst_n && o_valid && !i_stall;
        if (req_taken) begin
            expected_pixels.insert(expected_pixels.size(),
                                   unpremul_pixel(i_premul_pixel, argb_mode));
        end
        if (rsp_taken) begin
            if (expected_pixels.size() == 0) begin
                err_count++;
                if (err_count <= MaxReports) begin
                    $display("unexpected result: got %08h", o_out_pixel);
                end
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_pixel !== want) begin
                    err_count++;
                    if (err_count <= MaxReports) begin
                        $display("out_pixel mismatch: expected %08h, got %08h",
                                 want, o_out_pixel);
                    end
                end
            end
        end
    end

    // Driver: hold a stalled request, advance on acceptance, idle between requests.
    always @(negedge i_clk) begin
        int unsigned send_gap;
        int unsigned send_calm;
        bit          next_valid;
        next_valid = 1'b0;
        if (req_taken) begin
            void'(pending_reqs.pop_front());
            if (send_calm > 0) begin
                send_calm--;
                send_gap = 0;
            end else begin
                send_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 15) == 0) begin
                    send_calm = $urandom_range(10, 40);
                end
            end
        end
        if (i_valid && !req_taken) begin
            next_valid = 1'b1;               // stalled: keep the payload as it is
        end else if (send_gap > 0) begin
            send_gap--;
        end else if (pending_reqs.size() != 0) begin
            if (!(pending_reqs[0].drain_first && expected_pixels.size() != 0)) begin
                pending_reqs[0].drain_first = 1'b0;
                i_premul_pixel <= pending_reqs[0].pixel;
                next_valid = 1'b1;
            end
        end
        i_valid <= next_valid;
    end

    // Sink: draw a random stall after each result, with calm stretches, and
    // hold off twice for a long stretch so the pipeline fills and backs up.
    always @(negedge i_clk) begin
        int unsigned recv_gap;
        int unsigned recv_calm;
        int unsigned hold_left;
        int unsigned results_seen;
        if (rsp_taken) begin
            results_seen++;
            if (recv_calm > 0) begin
                recv_calm--;
                recv_gap = 0;
            end else begin
                recv_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 15) == 0) begin
                    recv_calm = $urandom_range(10, 40);
                end
            end
            if (results_seen == 150 || results_seen == 400) begin
                hold_left = LongHold;
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Wait until every request is accepted and answered, then let the pipe settle.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Write the order register while the block is idle.
    task automatic write_argb(bit value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        argb_mode    = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] directed[12];
        t_pixel_req  req;
        logic [7:0]  alpha;
        logic [7:0]  chan[3];
        bit          well_formed;
        directed = '{
            32'h0000_0000,   // zero alpha, zero color
            32'h00ff_ffff,   // zero alpha, color bytes ignored
            32'hff12_3456,   // full alpha: reorder only
            32'hffff_ffff,
            32'hff00_0000,
            32'h0101_0101,   // smallest partial alpha
            32'h0100_0100,
            32'h01ff_ffff,   // color above alpha: saturate
            32'hfefe_fe00,   // largest partial alpha
            32'hfe01_7ffd,
            32'h8040_2010,
            32'h80ff_8081    // all three channels at or above alpha: saturate
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests, first under the reset order, then under ARGB.
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                write_argb(1'b1);
            end
            foreach (directed[k]) begin
                req.pixel       = directed[k];
                req.drain_first = 1'b0;
                pending_reqs.insert(pending_reqs.size(), req);
            end
            wait_idle();
        end

        // Random phases, alternating the order register.
        for (int unsigned ph = 0; ph < RandPhases; ph++) begin
            write_argb(ph[0] == 1'b0 ? 1'b0 : 1'b1);
            for (int unsigned k = 0; k < RandPerPhase; k++) begin
                case ($urandom_range(0, 9))
                    0:       alpha = AlphaNone;
                    1:       alpha = AlphaFull;
                    2:       alpha = 8'($urandom_range(1, 3));
                    3:       alpha = 8'($urandom_range(252, 254));
                    default: alpha = 8'($urandom_range(0, 255));
                endcase
                // mostly valid premultiplied data, the rest arbitrary bytes
                well_formed = ($urandom_range(0, 3) != 0);
                foreach (chan[c]) begin
                    chan[c] = well_formed ? 8'($urandom_range(0, 32'(alpha)))
                                          : 8'($urandom_range(0, 255));
                end
                req.pixel       = {alpha, chan[2], chan[1], chan[0]};
                req.drain_first = (k == DrainAt);
                pending_reqs.insert(pending_reqs.size(), req);
            end
            wait_idle();
        end

        if (err_count == 0 && expected_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: end the run if the traffic never drains.
    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
